// ----- rtl/gregorian_day_number_convert_core_assert.svh -----
// assertion macros for the day number converter
// used by the top level, expects clk and rst_n in scope
`ifndef GREGORIAN_DAY_NUMBER_CONVERT_CORE_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GDNC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GDNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gdnc_pkg.sv -----
// shared types, constants and calendar tables for the day number converter
// no dependencies
package gdnc_pkg;

    // pipeline depth
    localparam int NSTG = 6;

    // valid ranges
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [22:0] JDN_MIN  = 23'd1721060;
    localparam logic [22:0] JDN_MAX  = 23'd5373484;

    // reciprocal multipliers for constant division
    localparam logic [12:0] DIV25_MUL  = 13'd5243;   // 2^17 / 25, rounded up
    localparam logic [14:0] DIV400Y_MUL = 15'd29398; // 2^32 / 146097, rounded down
    localparam logic [13:0] DIV4Y_MUL  = 14'd11483;  // 2^24 / 1461, rounded down
    localparam logic [8:0]  DIV153_MUL = 9'd428;     // 2^16 / 153, rounded down

    typedef struct packed {
        logic        req_type;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [22:0] in_day_number;
    } req_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [22:0] out_day_number;
        logic        result_valid;
    } rsp_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTG-1:0] load;
    } ctrl_t;

    // days before the start of month m, counted from march (153m+2)/5
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // length of a calendar month
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] r;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gregorian_day_number_convert_core.sv -----
// gregorian date <-> julian day number converter, six-stage pipeline
// throughput: one word per cycle while the output does not stall;
// an empty stage takes a word even while the output stalls
// reset clears the stage valid bits only; no clearing pass, ready right after reset
// depends on gdnc_pkg, gdnc_fwd, gdnc_rev and the assertion macro header
`include "gregorian_day_number_convert_core_assert.svh"

module gregorian_day_number_convert_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  gdnc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output gdnc_pkg::rsp_t rsp
);

    logic [gdnc_pkg::NSTG-1:0] valid_reg, valid_next;
    logic [gdnc_pkg::NSTG-1:0] kind_reg, kind_next;
    logic [gdnc_pkg::NSTG-1:0] ready;
    gdnc_pkg::ctrl_t           ctrl;
    gdnc_pkg::rsp_t            fwd_rsp;
    gdnc_pkg::rsp_t            rev_rsp;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        ready[gdnc_pkg::NSTG-1] = !valid_reg[gdnc_pkg::NSTG-1] || !rsp_stall;
        for (int k = gdnc_pkg::NSTG - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    // valid bits and request kind travel with the word
    always_comb
    begin
        valid_next[0] = ready[0] ? req_valid : valid_reg[0];
        kind_next[0]  = ready[0] ? req.req_type : kind_reg[0];
        for (int k = 1; k < gdnc_pkg::NSTG; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
            kind_next[k]  = ready[k] ? kind_reg[k-1] : kind_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign ctrl.load = ready;
    assign req_stall = !ready[0];

    // the two conversion datapaths
    gdnc_fwd u_fwd (
        .clk  (clk),
        .req  (req),
        .ctrl (ctrl),
        .rsp  (fwd_rsp)
    );

    gdnc_rev u_rev (
        .clk  (clk),
        .req  (req),
        .ctrl (ctrl),
        .rsp  (rev_rsp)
    );

    // output select by request kind
    assign rsp_valid = valid_reg[gdnc_pkg::NSTG-1];
    assign rsp       = kind_reg[gdnc_pkg::NSTG-1] ? rev_rsp : fwd_rsp;

    // checks
    `GDNC_ASSERT_NOW(a_invalid_zero, rsp_valid && !rsp.result_valid, (rsp.out_year == 14'd0) && (rsp.out_month == 4'd0) && (rsp.out_day == 5'd0) && (rsp.out_day_number == 23'd0), "invalid response carries nonzero fields")
    `GDNC_ASSERT_NOW(a_valid_date, rsp_valid && rsp.result_valid, (rsp.out_month >= 4'd1) && (rsp.out_month <= 4'd12) && (rsp.out_day >= 5'd1) && (rsp.out_year <= gdnc_pkg::YEAR_MAX), "valid response with a bad date")
    `GDNC_ASSERT_NOW(a_valid_jdn, rsp_valid && rsp.result_valid, (rsp.out_day_number >= gdnc_pkg::JDN_MIN) && (rsp.out_day_number <= gdnc_pkg::JDN_MAX), "valid response with day number out of range")
    `GDNC_ASSERT_NOW(a_stall_full, req_stall, &valid_reg, "request stalled with an empty stage")
    `GDNC_ASSERT_NEXT(a_accept_fill, req_valid && !req_stall, valid_reg[0], "accepted word not in first stage")

endmodule

// ----- rtl/gdnc_fwd.sv -----
// date to day number datapath, three working stages then delay to the output stage
// depends on gdnc_pkg
module gdnc_fwd (
    input  logic           clk,
    input  gdnc_pkg::req_t req,
    input  gdnc_pkg::ctrl_t ctrl,
    output gdnc_pkg::rsp_t rsp
);

    typedef struct packed {
        logic [14:0] y;
        logic [8:0]  mt;
        logic [4:0]  day;
        logic [13:0] year;
        logic [3:0]  month;
        logic        ok;
        logic [24:0] yq_prod;
        logic [25:0] cq_prod;
    } f1_t;

    typedef struct packed {
        logic [23:0] y365;
        logic [12:0] yq4;
        logic [7:0]  c100;
        logic [9:0]  mt_day;
        logic [4:0]  day;
        logic [13:0] year;
        logic [3:0]  month;
        logic        leap;
        logic        ok;
    } f2_t;

    f1_t s1_reg, s1_next;
    f2_t s2_reg, s2_next;
    gdnc_pkg::rsp_t s3_reg, s3_next;
    gdnc_pkg::rsp_t s4_reg, s5_reg, s6_reg;

    logic        a;
    logic [7:0]  yd;
    logic [11:0] yrem;
    logic [23:0] sum;

    // stage 1: shift to a march-based year, start the /100 multiplies
    always_comb
    begin
        a = (req.in_month <= 4'd2);
        s1_next.y     = 15'(req.in_year) + 15'd4800 - 15'(a);
        s1_next.mt    = gdnc_pkg::month_offset(a ? req.in_month + 4'd9
                                                 : req.in_month - 4'd3);
        s1_next.day   = req.in_day;
        s1_next.year  = req.in_year;
        s1_next.month = req.in_month;
        s1_next.ok    = (req.in_year <= gdnc_pkg::YEAR_MAX) && (req.in_month >= 4'd1) &&
                        (req.in_month <= 4'd12) && (req.in_day != 5'd0);
        s1_next.yq_prod = 25'(req.in_year[13:2]) * 25'(gdnc_pkg::DIV25_MUL);
        s1_next.cq_prod = 26'(s1_next.y[14:2]) * 26'(gdnc_pkg::DIV25_MUL);
    end

    // stage 2: leap year test, 365 y, century count
    always_comb
    begin
        yd   = s1_reg.yq_prod[24:17];
        yrem = s1_reg.year[13:2] - 12'(12'(yd) * 12'd25);
        s2_next.y365   = 24'(s1_reg.y) * 24'd365;
        s2_next.yq4    = s1_reg.y[14:2];
        s2_next.c100   = s1_reg.cq_prod[24:17];
        s2_next.mt_day = 10'(s1_reg.mt) + 10'(s1_reg.day);
        s2_next.day    = s1_reg.day;
        s2_next.year   = s1_reg.year;
        s2_next.month  = s1_reg.month;
        s2_next.leap   = (s1_reg.year[1:0] == 2'd0) && ((yrem != 12'd0) || (yd[1:0] == 2'd0));
        s2_next.ok     = s1_reg.ok;
    end

    // stage 3: final sum and day-of-month check, zero when invalid
    always_comb
    begin
        sum = s2_reg.y365 + 24'(s2_reg.yq4) + 24'(s2_reg.c100[7:2]) + 24'(s2_reg.mt_day)
              - 24'(s2_reg.c100) - 24'd32045;
        s3_next = '0;
        if (s2_reg.ok && (s2_reg.day <= gdnc_pkg::month_days(s2_reg.month, s2_reg.leap)))
        begin
            s3_next.out_year       = s2_reg.year;
            s3_next.out_month      = s2_reg.month;
            s3_next.out_day        = s2_reg.day;
            s3_next.out_day_number = sum[22:0];
            s3_next.result_valid   = 1'b1;
        end
    end

    // stage registers, loaded as the word moves on
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_reg <= s1_next;
        end
        if (ctrl.load[1])
        begin
            s2_reg <= s2_next;
        end
        if (ctrl.load[2])
        begin
            s3_reg <= s3_next;
        end
        if (ctrl.load[3])
        begin
            s4_reg <= s3_reg;
        end
        if (ctrl.load[4])
        begin
            s5_reg <= s4_reg;
        end
        if (ctrl.load[5])
        begin
            s6_reg <= s5_reg;
        end
    end

    assign rsp = s6_reg;

endmodule

// ----- rtl/gdnc_rev.sv -----
// day number to date datapath, six stages of reciprocal divides with correction
// depends on gdnc_pkg
module gdnc_rev (
    input  logic           clk,
    input  gdnc_pkg::req_t req,
    input  gdnc_pkg::ctrl_t ctrl,
    output gdnc_pkg::rsp_t rsp
);

    typedef struct packed {
        logic [25:0] x;
        logic [40:0] bprod;
        logic [22:0] jdn;
        logic        ok;
    } r1_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [18:0] rem;
        logic [22:0] jdn;
        logic        ok;
    } r2_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [17:0] x2;
        logic [31:0] dprod;
        logic [22:0] jdn;
        logic        ok;
    } r3_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [7:0]  d;
        logic [11:0] rem2;
        logic [22:0] jdn;
        logic        ok;
    } r4_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [7:0]  d;
        logic [8:0]  e;
        logic [10:0] x3;
        logic [19:0] mprod;
        logic [22:0] jdn;
        logic        ok;
    } r5_t;

    r1_t s1_reg, s1_next;
    r2_t s2_reg, s2_next;
    r3_t s3_reg, s3_next;
    r4_t s4_reg, s4_next;
    r5_t s5_reg, s5_next;
    gdnc_pkg::rsp_t s6_reg, s6_next;

    logic [23:0] a24;
    logic [7:0]  b_est;
    logic        fix_b;
    logic [18:0] r1;
    logic [7:0]  d_est;
    logic        fix_d;
    logic [11:0] r2;
    logic [3:0]  m_est;
    logic [10:0] rem3;
    logic [3:0]  m;
    logic        hi;
    logic [14:0] oy;

    // stage 1: 4(jdn + 32044) + 3, estimate of the 400-year cycle
    always_comb
    begin
        a24 = 24'(req.in_day_number) + 24'd32044;
        s1_next.x     = {a24, 2'b11};
        s1_next.bprod = 41'(s1_next.x) * 41'(gdnc_pkg::DIV400Y_MUL);
        s1_next.jdn   = req.in_day_number;
        s1_next.ok    = (req.in_day_number >= gdnc_pkg::JDN_MIN) &&
                        (req.in_day_number <= gdnc_pkg::JDN_MAX);
    end

    // stage 2: remainder against the estimate
    always_comb
    begin
        b_est = s1_reg.bprod[39:32];
        s2_next.b   = b_est;
        s2_next.rem = 19'(s1_reg.x - 26'(26'(b_est) * 26'd146097));
        s2_next.jdn = s1_reg.jdn;
        s2_next.ok  = s1_reg.ok;
    end

    // stage 3: correct the cycle count, estimate the 4-year count
    always_comb
    begin
        fix_b = (s2_reg.rem >= 19'd146097);
        r1    = fix_b ? s2_reg.rem - 19'd146097 : s2_reg.rem;
        s3_next.b     = s2_reg.b + 8'(fix_b);
        s3_next.x2    = {r1[17:2], 2'b11};
        s3_next.dprod = 32'(s3_next.x2) * 32'(gdnc_pkg::DIV4Y_MUL);
        s3_next.jdn   = s2_reg.jdn;
        s3_next.ok    = s2_reg.ok;
    end

    // stage 4: remainder against the 4-year estimate
    always_comb
    begin
        d_est = s3_reg.dprod[31:24];
        s4_next.b    = s3_reg.b;
        s4_next.d    = d_est;
        s4_next.rem2 = 12'(s3_reg.x2 - 18'(18'(d_est) * 18'd1461));
        s4_next.jdn  = s3_reg.jdn;
        s4_next.ok   = s3_reg.ok;
    end

    // stage 5: correct the 4-year count, day of year, month estimate
    always_comb
    begin
        fix_d = (s4_reg.rem2 >= 12'd1461);
        r2    = fix_d ? s4_reg.rem2 - 12'd1461 : s4_reg.rem2;
        s5_next.b     = s4_reg.b;
        s5_next.d     = s4_reg.d + 8'(fix_d);
        s5_next.e     = r2[10:2];
        s5_next.x3    = 11'(11'(s5_next.e) * 11'd5 + 11'd2);
        s5_next.mprod = 20'(s5_next.x3) * 20'(gdnc_pkg::DIV153_MUL);
        s5_next.jdn   = s4_reg.jdn;
        s5_next.ok    = s4_reg.ok;
    end

    // stage 6: correct the month, build the date, zero when invalid
    always_comb
    begin
        m_est = s5_reg.mprod[19:16];
        rem3  = s5_reg.x3 - 11'(11'(m_est) * 11'd153);
        m     = m_est + 4'(rem3 >= 11'd153);
        hi    = (m >= 4'd10);
        oy    = 15'(s5_reg.b) * 15'd100 + 15'(s5_reg.d) + 15'(hi) - 15'd4800;
        s6_next = '0;
        if (s5_reg.ok)
        begin
            s6_next.out_year       = oy[13:0];
            s6_next.out_month      = hi ? m - 4'd9 : m + 4'd3;
            s6_next.out_day        = 5'(s5_reg.e - gdnc_pkg::month_offset(m) + 9'd1);
            s6_next.out_day_number = s5_reg.jdn;
            s6_next.result_valid   = 1'b1;
        end
    end

    // stage registers, loaded as the word moves on
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_reg <= s1_next;
        end
        if (ctrl.load[1])
        begin
            s2_reg <= s2_next;
        end
        if (ctrl.load[2])
        begin
            s3_reg <= s3_next;
        end
        if (ctrl.load[3])
        begin
            s4_reg <= s4_next;
        end
        if (ctrl.load[4])
        begin
            s5_reg <= s5_next;
        end
        if (ctrl.load[5])
        begin
            s6_reg <= s6_next;
        end
    end

    assign rsp = s6_reg;

endmodule
